/* sv/dstc_pkg.sv */
// Package for the trace classifier: verdict codes and shared control types.
// No dependencies.
`timescale 1ns / 1ps
package dstc_pkg;
  typedef enum logic [2:0] {
    VERDICT_STACK      = 3'd0,
    VERDICT_PRIORITY_Q = 3'd1,
    VERDICT_QUEUE      = 3'd2,
    VERDICT_NOT_SURE   = 3'd3,
    VERDICT_IMPOSSIBLE = 3'd4
  } verdict_t;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_IGNORE = 2'd2,
    REQ_SPARE  = 2'd3
  } req_t;

  // Request from the sequencer to the heap engine.
  typedef struct packed {
    logic start;
    logic push;
  } heap_cmd_t;

  // Status of the heap engine; miss holds until the next start, clear or reset.
  typedef struct packed {
    logic busy;
    logic miss;
  } heap_sts_t;

  function automatic verdict_t classify(input logic lifo_ok, input logic heap_ok,
                                        input logic fifo_ok);
    verdict_t v;
    v = VERDICT_NOT_SURE;
    if (lifo_ok && !heap_ok && !fifo_ok) v = VERDICT_STACK;
    else if (!lifo_ok && heap_ok && !fifo_ok) v = VERDICT_PRIORITY_Q;
    else if (!lifo_ok && !heap_ok && fifo_ok) v = VERDICT_QUEUE;
    else if (!lifo_ok && !heap_ok && !fifo_ok) v = VERDICT_IMPOSSIBLE;
    return v;
  endfunction
endpackage

/* sv/dstc_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module dstc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

/* sv/dstc_heap.sv */
// Max-heap engine over a single-port RAM: sift-up reads each parent, sift-down
// both children. Depends on dstc_pkg and dstc_ram. Keys are order-preserving unsigned.
`timescale 1ns / 1ps
module dstc_heap #(
  parameter int DEPTH = 1024,
  parameter int KW    = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  dstc_pkg::heap_cmd_t      cmd,
  input  logic [KW-1:0]            key,
  input  logic                     clear,
  output dstc_pkg::heap_sts_t      sts,
  output logic [$clog2(DEPTH):0]   count
);
  import dstc_pkg::*;

  localparam int AW = $clog2(DEPTH);

  typedef enum logic [11:0] {
    H_IDLE     = 12'b000000000001,
    H_UP_RD    = 12'b000000000010,
    H_UP_CMP   = 12'b000000000100,
    H_TOP_RD   = 12'b000000001000,
    H_TOP_CMP  = 12'b000000010000,
    H_LAST_RD  = 12'b000000100000,
    H_LAST_CAP = 12'b000001000000,
    H_C1_RD    = 12'b000010000000,
    H_C2_RD    = 12'b000100000000,
    H_CCMP     = 12'b001000000000,
    H_PLACE    = 12'b010000000000,
    H_DONE     = 12'b100000000000
  } hst_t;

  hst_t            st;
  logic [AW-1:0]   idx;      // current hole position
  logic [KW-1:0]   k;        // key being placed
  logic [KW-1:0]   c1;       // left child value
  logic            has2;     // right child exists
  logic            miss;
  logic            we;
  logic [AW-1:0]   addr;
  logic [KW-1:0]   wdata, rdata;
  logic [AW-1:0]   par;
  logic [AW:0]     lch, lch_p1, best_idx;
  logic            c2_gt;
  logic [KW-1:0]   best;

  dstc_ram #(.WIDTH(KW), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  assign par      = (idx - AW'(1)) >> 1;
  assign lch      = {idx, 1'b1};
  assign lch_p1   = lch + (AW+1)'(1);
  assign c2_gt    = has2 && (rdata > c1);
  assign best     = c2_gt ? rdata : c1;
  assign best_idx = c2_gt ? lch_p1 : lch;
  assign sts.busy = (st != H_IDLE);
  assign sts.miss = miss;

  always_comb begin
    we = 1'b0;
    addr = idx;
    wdata = k;
    unique case (st)
      H_UP_RD:   addr = par;
      H_UP_CMP:  begin
        // move the parent down into the hole
        if (rdata < k) begin
          we = 1'b1;
          wdata = rdata;
        end
      end
      H_TOP_RD:  addr = '0;
      H_LAST_RD: addr = count[AW-1:0];
      H_C1_RD:   addr = lch[AW-1:0];
      H_C2_RD:   addr = lch_p1[AW-1:0];
      H_CCMP:    begin
        // move the larger child up into the hole
        if (best > k) begin
          we = 1'b1;
          wdata = best;
        end
      end
      H_PLACE:   we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      st <= H_IDLE;
      count <= '0;
      miss <= 1'b0;
    end else begin
      unique case (st)
        H_IDLE: if (cmd.start) begin
          k <= key;
          miss <= 1'b0;
          if (cmd.push) begin
            idx <= count[AW-1:0];
            count <= count + (AW+1)'(1);
            st <= H_UP_RD;
          end else if (count == '0) begin
            miss <= 1'b1;
            st <= H_DONE;
          end else begin
            st <= H_TOP_RD;
          end
        end
        H_UP_RD:  st <= (idx == '0) ? H_PLACE : H_UP_CMP;
        H_UP_CMP: begin
          if (rdata < k) begin
            idx <= par;
            st <= H_UP_RD;
          end else begin
            st <= H_PLACE;
          end
        end
        H_TOP_RD:  st <= H_TOP_CMP;
        H_TOP_CMP: begin
          if (rdata != k) begin
            miss <= 1'b1;
            st <= H_DONE;
          end else begin
            count <= count - (AW+1)'(1);
            st <= (count == (AW+1)'(1)) ? H_DONE : H_LAST_RD;
          end
        end
        H_LAST_RD: begin
          idx <= '0;
          st <= H_LAST_CAP;
        end
        H_LAST_CAP: begin
          k <= rdata;
          st <= H_C1_RD;
        end
        H_C1_RD: st <= (lch >= count) ? H_PLACE : H_C2_RD;
        H_C2_RD: begin
          c1 <= rdata;
          has2 <= (lch_p1 < count);
          st <= H_CCMP;
        end
        H_CCMP: begin
          if (best > k) begin
            idx <= best_idx[AW-1:0];
            st <= H_C1_RD;
          end else begin
            st <= H_PLACE;
          end
        end
        H_PLACE: st <= H_DONE;
        H_DONE:  st <= H_IDLE;
        default: st <= H_IDLE;
      endcase
    end
  end
endmodule

/* sv/data_structure_trace_classifier.sv */
// Top level of the trace classifier; depends on dstc_pkg, dstc_ram and dstc_heap.
//
// Usage: the input channel (s_*) carries one trace operation per transfer:
// insert, remove-expecting-value, or an ignored code. s_tlast marks the last
// operation of a trace. The output channel (m_*) carries one verdict per trace
// with the sticky overflow flag, offered in the cycle the block becomes ready
// again after the last operation.
// Timing: the block takes one transfer, then drops s_tready while the FIFO,
// LIFO and heap models work. An ignored operation, or an insert with the
// heap full, passes through S_START and S_FINISH only. An insert also waits
// in S_WAIT while the value climbs in the heap. A remove checks the FIFO and
// LIFO heads in S_CHECK, then waits in S_WAIT while the heap checks its top
// and sifts down.
// Stalls: a verdict that is not taken holds m_tdata; the block keeps taking
// operations of the next trace and only waits at that trace's last operation.
// Reset: all models empty, all consistency flags set, overflow cleared.
`timescale 1ns / 1ps
module data_structure_trace_classifier #(
  parameter int DEPTH      = 1024,
  parameter int VALUE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [1:0] req_type, [33:2] value, zero pad
  input  logic        s_tlast,   // last_op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // [2:0] verdict, [3] overflow, zero pad
);
  import dstc_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int KW = VALUE_BITS;
  localparam logic [AW:0]   FULL_C = (AW+1)'(DEPTH);
  localparam logic [AW-1:0] WRAP_C = AW'(DEPTH - 1);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_START  = 5'b00010,
    S_CHECK  = 5'b00100,
    S_WAIT   = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t          st;
  req_t            op;
  logic [KW-1:0]   key;
  logic            last;
  logic [AW-1:0]   fifo_head, fifo_tail;
  logic [AW:0]     fifo_count, lifo_count;
  logic            fifo_ok, lifo_ok, heap_ok, overflow_seen;

  logic [63:0]     v64;
  logic [KW-1:0]   in_key;
  logic            is_ins, is_rem;
  logic            fifo_full, fifo_empty, lifo_full, lifo_empty, heap_full;
  logic            out_free, load_res;
  logic            fifo_we, lifo_we;
  logic [AW-1:0]   fifo_addr, lifo_addr;
  logic [KW-1:0]   fifo_rdata, lifo_rdata;
  heap_cmd_t       heap_cmd;
  heap_sts_t       heap_sts;
  logic [AW:0]     heap_count;

  // Sign-extend the 32-bit value, keep VALUE_BITS of it and flip the sign bit
  // so that unsigned compares order the keys as signed values.
  assign v64    = {{32{s_tdata[33]}}, s_tdata[33:2]};
  assign in_key = {~v64[KW-1], v64[KW-2:0]};

  assign is_ins     = (op == REQ_INSERT);
  assign is_rem     = (op == REQ_REMOVE);
  assign fifo_full  = (fifo_count == FULL_C);
  assign fifo_empty = (fifo_count == '0);
  assign lifo_full  = (lifo_count == FULL_C);
  assign lifo_empty = (lifo_count == '0);
  assign heap_full  = (heap_count == FULL_C);

  // Result register is free when empty or being taken this cycle.
  assign out_free = !m_tvalid || m_tready;
  assign load_res = (st == S_FINISH) && last && out_free;

  assign s_tready = (st == S_IDLE);

  // Writes happen on insert, reads of the heads on remove, both in S_START.
  always_comb begin
    fifo_we = (st == S_START) && is_ins && !fifo_full;
    lifo_we = (st == S_START) && is_ins && !lifo_full;
    fifo_addr = is_ins ? fifo_tail : fifo_head;
    lifo_addr = is_ins ? lifo_count[AW-1:0] : lifo_count[AW-1:0] - AW'(1);
    heap_cmd.start = (st == S_START) && ((is_ins && !heap_full) || is_rem);
    heap_cmd.push = is_ins;
  end

  dstc_ram #(.WIDTH(KW), .DEPTH(DEPTH)) u_fifo_ram (
    .clk(clk), .we(fifo_we), .addr(fifo_addr), .wdata(key), .rdata(fifo_rdata)
  );

  dstc_ram #(.WIDTH(KW), .DEPTH(DEPTH)) u_lifo_ram (
    .clk(clk), .we(lifo_we), .addr(lifo_addr), .wdata(key), .rdata(lifo_rdata)
  );

  dstc_heap #(.DEPTH(DEPTH), .KW(KW)) u_heap (
    .clk(clk), .rst(rst), .cmd(heap_cmd), .key(key), .clear(load_res),
    .sts(heap_sts), .count(heap_count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      fifo_head <= '0;
      fifo_tail <= '0;
      fifo_count <= '0;
      lifo_count <= '0;
      fifo_ok <= 1'b1;
      lifo_ok <= 1'b1;
      heap_ok <= 1'b1;
      overflow_seen <= 1'b0;
      m_tvalid <= 1'b0;
      m_tdata <= '0;
    end else begin
      // Output register: load a verdict or drop valid once taken.
      if (load_res) begin
        m_tvalid <= 1'b1;
        m_tdata <= {4'b0, overflow_seen, classify(lifo_ok, heap_ok, fifo_ok)};
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (st)
        S_IDLE: if (s_tvalid) begin
          op <= req_t'(s_tdata[1:0]);
          key <= in_key;
          last <= s_tlast;
          st <= S_START;
        end
        S_START: begin
          if (is_ins) begin
            // Each model checks its own fill level; a full one drops the value.
            if (!fifo_full) begin
              fifo_tail <= (fifo_tail == WRAP_C) ? '0 : fifo_tail + AW'(1);
              fifo_count <= fifo_count + (AW+1)'(1);
            end
            if (!lifo_full) lifo_count <= lifo_count + (AW+1)'(1);
            if (fifo_full || lifo_full || heap_full) overflow_seen <= 1'b1;
            st <= heap_full ? S_FINISH : S_WAIT;
          end else if (is_rem) begin
            st <= S_CHECK;
          end else begin
            st <= S_FINISH;
          end
        end
        S_CHECK: begin
          // Heads read in S_START are valid now; pop on a match, else clear flag.
          if (fifo_empty || fifo_rdata != key) begin
            fifo_ok <= 1'b0;
          end else begin
            fifo_head <= (fifo_head == WRAP_C) ? '0 : fifo_head + AW'(1);
            fifo_count <= fifo_count - (AW+1)'(1);
          end
          if (lifo_empty || lifo_rdata != key) lifo_ok <= 1'b0;
          else lifo_count <= lifo_count - (AW+1)'(1);
          st <= S_WAIT;
        end
        S_WAIT: if (!heap_sts.busy) begin
          if (is_rem && heap_sts.miss) heap_ok <= 1'b0;
          st <= S_FINISH;
        end
        S_FINISH: begin
          if (!last) begin
            st <= S_IDLE;
          end else if (out_free) begin
            // Verdict loaded above; start the next trace from scratch.
            fifo_head <= '0;
            fifo_tail <= '0;
            fifo_count <= '0;
            lifo_count <= '0;
            fifo_ok <= 1'b1;
            lifo_ok <= 1'b1;
            heap_ok <= 1'b1;
            overflow_seen <= 1'b0;
            st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule

/* tb/tb_top.sv */
// Self-checking bench for the trace classifier: replays insert/remove traces,
// predicts each verdict with a behavioral FIFO/LIFO/heap replay and compares.
// Depends on dstc_pkg and data_structure_trace_classifier.
`timescale 1ns / 1ps
module tb_top;
  import dstc_pkg::*;

  localparam int DEPTH = 1024;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    req_t        op;
    logic [31:0] value;
    logic        last;
  } trace_op_t;

  typedef struct packed {
    verdict_t verdict;
    logic     overflow;
  } verdict_rec_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;

  data_structure_trace_classifier u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #6 clk = ~clk;

  // Shadow copies of the three structures. Signed ints give the heap ordering.
  int fifo_q[$];
  int lifo_q[$];
  int heap_q[$];
  bit fifo_ok = 1'b1;
  bit lifo_ok = 1'b1;
  bit heap_ok = 1'b1;
  bit ovf_seen = 1'b0;

  trace_op_t    pending_ops[$];
  verdict_rec_t expected_verdicts[$];
  int  errors = 0;
  int  verdicts_seen = 0;
  int  ops_sent = 0;
  int  send_idle_pct;
  int  recv_idle_pct;
  bit  hold_sender;
  int  quiet_cycles = 0;
  int  verdict_hist[5];

  function automatic int heap_max_idx();
    int best;
    best = 0;
    for (int i = 1; i < heap_q.size(); i++)
      if (heap_q[i] > heap_q[best]) best = i;
    return best;
  endfunction

  // Apply one transfer to the shadow structures; queue a verdict on last.
  function automatic void predict_classify(trace_op_t t);
    int v;
    int hi;
    verdict_rec_t r;
    v = $signed(t.value);
    if (t.op == REQ_INSERT) begin
      if (fifo_q.size() < DEPTH) fifo_q.insert(fifo_q.size(), v); else ovf_seen = 1;
      if (lifo_q.size() < DEPTH) lifo_q.insert(lifo_q.size(), v); else ovf_seen = 1;
      if (heap_q.size() < DEPTH) heap_q.insert(heap_q.size(), v); else ovf_seen = 1;
    end else if (t.op == REQ_REMOVE) begin
      // Each model pops on a match regardless of its flag.
      if (fifo_q.size() == 0 || fifo_q[0] != v) fifo_ok = 0;
      else void'(fifo_q.pop_front());
      if (heap_q.size() == 0) heap_ok = 0;
      else begin
        hi = heap_max_idx();
        if (heap_q[hi] != v) heap_ok = 0; else heap_q.delete(hi);
      end
      if (lifo_q.size() == 0 || lifo_q[$] != v) lifo_ok = 0;
      else void'(lifo_q.pop_back());
    end
    if (t.last) begin
      if (lifo_ok && !heap_ok && !fifo_ok) r.verdict = VERDICT_STACK;
      else if (!lifo_ok && heap_ok && !fifo_ok) r.verdict = VERDICT_PRIORITY_Q;
      else if (!lifo_ok && !heap_ok && fifo_ok) r.verdict = VERDICT_QUEUE;
      else if (lifo_ok || heap_ok || fifo_ok) r.verdict = VERDICT_NOT_SURE;
      else r.verdict = VERDICT_IMPOSSIBLE;
      r.overflow = ovf_seen;
      expected_verdicts.insert(expected_verdicts.size(), r);
      fifo_q.delete(); lifo_q.delete(); heap_q.delete();
      fifo_ok = 1; lifo_ok = 1; heap_ok = 1; ovf_seen = 0;
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d (verdict #%0d)", what, got, want,
             verdicts_seen);
    errors++;
  endtask

  // Driver: advance to the next pending transfer after each handshake.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_classify({req_t'(s_tdata[1:0]), s_tdata[33:2], s_tlast});
        ops_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_ops.size() > 0 && !hold_sender &&
            $urandom_range(99) >= send_idle_pct) begin
          trace_op_t t;
          t = pending_ops.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {6'b0, t.value, t.op};
          s_tlast  <= t.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transfer and throttle tready.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch("unexpected result", m_tdata, -1);
        end else begin
          verdict_rec_t w;
          w = expected_verdicts.pop_front();
          if (m_tdata[2:0] != w.verdict) report_mismatch("verdict", m_tdata[2:0], w.verdict);
          if (m_tdata[3] != w.overflow) report_mismatch("overflow", m_tdata[3], w.overflow);
          if (m_tdata[7:4] != 4'b0) report_mismatch("pad bits", m_tdata[7:4], 0);
          if (w.verdict <= VERDICT_IMPOSSIBLE) verdict_hist[w.verdict]++;
        end
        verdicts_seen++;
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: count cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", quiet_cycles);
      $display("tb_top: FAIL");
      $finish;
    end
  end

  function automatic logic [31:0] pick_value(int span);
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom();
      default: return $urandom_range(span) - span / 2;
    endcase
  endfunction

  function automatic void add_op(req_t op, logic [31:0] v, logic last);
    trace_op_t t;
    t.op = op; t.value = v; t.last = last;
    pending_ops.insert(pending_ops.size(), t);
  endfunction

  // Trace shaped after one structure, with optional corruption; ends in a random operation.
  function automatic void add_trace(int kind, int n, bit corrupt);
    int pool[$];
    int v, hi;
    for (int i = 0; i < n; i++) begin
      if (pool.size() == 0 || $urandom_range(2) != 0) begin
        v = pick_value(40);
        pool.insert(pool.size(), v);
        add_op(REQ_INSERT, v, 1'b0);
      end else begin
        case (kind)
          0: v = pool.pop_back();
          1: begin
            hi = 0;
            for (int j = 1; j < pool.size(); j++) if (pool[j] > pool[hi]) hi = j;
            v = pool[hi]; pool.delete(hi);
          end
          default: v = pool.pop_front();
        endcase
        if (corrupt && $urandom_range(5) == 0) v = v + 1;
        add_op(REQ_REMOVE, v, 1'b0);
      end
      if ($urandom_range(15) == 0) add_op(req_t'($urandom_range(2, 3)), $urandom(), 1'b0);
    end
    add_op(req_t'($urandom_range(3)), pick_value(40), 1'b1);
  endfunction

  task automatic drain();
    while (pending_ops.size() > 0 || s_tvalid || expected_verdicts.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    rst = 1;
    hold_sender = 0;
    send_idle_pct = 14; recv_idle_pct = 87;
    repeat (9) @(posedge clk);
    rst <= 0;

    // Directed: each verdict, extreme values, ignored ops, lone last.
    add_op(REQ_INSERT, 32'h8000_0000, 0); add_op(REQ_INSERT, 32'h7fff_ffff, 0);
    add_op(REQ_REMOVE, 32'h7fff_ffff, 0); add_op(REQ_REMOVE, 32'h8000_0000, 1); // not sure
    add_op(REQ_INSERT, 1, 0); add_op(REQ_INSERT, 5, 0); add_op(REQ_INSERT, 3, 0);
    add_op(REQ_REMOVE, 3, 1);                                                   // stack
    add_op(REQ_INSERT, 1, 0); add_op(REQ_INSERT, 5, 0); add_op(REQ_INSERT, 3, 0);
    add_op(REQ_REMOVE, 5, 1);                                                   // priority
    add_op(REQ_INSERT, 1, 0); add_op(REQ_INSERT, 5, 0); add_op(REQ_REMOVE, 1, 1); // queue
    add_op(REQ_REMOVE, 7, 1);                                                   // impossible
    add_op(REQ_SPARE, 32'hffff_ffff, 0); add_op(REQ_IGNORE, 0, 1);
    add_op(REQ_SPARE, 0, 1);
    add_op(REQ_INSERT, 32'hffff_ffff, 0); add_op(REQ_REMOVE, 32'hffff_ffff, 0);
    add_op(REQ_REMOVE, 32'hffff_ffff, 1);
    drain();

    // Fill past depth once to hit the overflow path; then a fresh trace.
    for (int i = 0; i < DEPTH + 3; i++) add_op(REQ_INSERT, $urandom(), 0);
    add_op(REQ_IGNORE, 0, 1);
    add_op(REQ_INSERT, 2, 1);
    drain();

    // Random traces over three idle profiles.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 87 : 0;
      recv_idle_pct = (phase == 0) ? 87 : (phase == 1) ? 14 : 0;
      for (int n = 0; n < 20; n++) begin
        if ($urandom_range(9) == 0) begin
          int len;
          len = $urandom_range(1, 8);
          for (int i = 0; i < len; i++)
            add_op(req_t'($urandom_range(3)), pick_value(8), i == len - 1);
        end else begin
          add_trace($urandom_range(2), $urandom_range(1, 14), $urandom_range(3) == 0);
        end
      end
      // Hold off the sender until every outstanding verdict is back.
      if (phase == 1) begin
        hold_sender = 1;
        while (s_tvalid || expected_verdicts.size() > 0) @(posedge clk);
        hold_sender = 0;
      end
      // Let this profile finish before the next one starts.
      while (pending_ops.size() > 0 || s_tvalid) @(posedge clk);
    end
    while (expected_verdicts.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("covered %0d operations, %0d verdicts (stack %0d, prio %0d, queue %0d,",
             ops_sent, verdicts_seen, verdict_hist[0], verdict_hist[1], verdict_hist[2]);
    $display("  unsure %0d, impossible %0d), one overflowed trace", verdict_hist[3],
             verdict_hist[4]);
    if (errors == 0 && expected_verdicts.size() == 0 && pending_ops.size() == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end
endmodule

/* files.f */
sv/dstc_pkg.sv
sv/dstc_ram.sv
sv/dstc_heap.sv
sv/data_structure_trace_classifier.sv
tb/tb_top.sv
